// File: rtl/mh_sig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_sig_pkg
// Shared widths, item codes and the mod (2^61 - 1) reduction used by the
// MinHash signature core.
// ----------------------------------------------------------------------------
package mh_sig_pkg;

    localparam int SLOT_W    = 6;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int MAX_PERMS = 64;

    // Mersenne prime 2^61 - 1, held at the 62-bit width of the folded sum
    localparam logic [61:0] MERSENNE_61 = 62'h1FFF_FFFF_FFFF_FFFF;

    localparam logic [WORD_W-1:0] WORD_ONES = '1;

    typedef enum logic
    {
        FUNC_LOAD = 1'b0,
        FUNC_FOLD = 1'b1
    } func_t;

    // x = hi * 2^61 + lo  ==>  x mod M = (hi + lo) mod M, and hi + lo < 2 * M,
    // so one compare and subtract finishes the reduction.
    function automatic logic [WORD_W-1:0] mod_m61_low(input logic [PROD_W-1:0] x);
        logic [61:0] folded;
        logic [61:0] reduced;
        folded  = {1'b0, x[60:0]} + {59'b0, x[63:61]};
        reduced = (folded >= MERSENNE_61) ? (folded - MERSENNE_61) : folded;
        return reduced[WORD_W-1:0];
    endfunction

endpackage

// File: rtl/minhash_signature_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minhash_signature_core
// MinHash signature over a set of 32-bit values with per-slot universal hash
// (a*v + b) mod (2^61 - 1), coefficients and running minimums kept in RAM.
// ----------------------------------------------------------------------------
// A load transfer (func = 0) writes one coefficient pair and the core stays
// ready for the next transfer. A value transfer (func = 1) sweeps every slot
// through a four-stage read / multiply / add / reduce-and-min pipeline, one
// slot per cycle on the single read port of the signature RAM, so the core
// holds in_stall at least until the pipeline drains. A value marked last is
// followed by NUM_PERMS result transfers in slot order, each slot read only
// once the previous word has landed in the output register; the next input
// can be taken while the final word still waits in the output register. The
// signature RAM reads as all ones per slot from reset until that slot is first
// written; the coefficient RAM is undefined until loaded.
module minhash_signature_core
#(
    parameter int NUM_PERMS = mh_sig_pkg::MAX_PERMS
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [mh_sig_pkg::SLOT_W-1:0]   slot,
    input  logic [mh_sig_pkg::WORD_W-1:0]   coef_a,
    input  logic [mh_sig_pkg::WORD_W-1:0]   coef_b,
    input  logic [mh_sig_pkg::WORD_W-1:0]   value,
    input  logic                            first,
    input  logic                            last,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mh_sig_pkg::WORD_W-1:0]   signature_word,
    output logic [mh_sig_pkg::SLOT_W-1:0]   slot_index,
    output logic                            final_word
);

    import mh_sig_pkg::*;

    localparam int AW = (NUM_PERMS > 1) ? $clog2(NUM_PERMS) : 1;
    localparam logic [AW-1:0]     LAST_IDX  = AW'(NUM_PERMS - 1);
    localparam logic [SLOT_W:0]   PERMS_EXT = (SLOT_W + 1)'(NUM_PERMS);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_FOLD,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          cnt_reg;
    logic                   p1_vld_reg;
    logic                   p2_vld_reg;
    logic                   p3_vld_reg;
    logic                   pend_reg;
    logic                   out_valid_reg;
    logic [NUM_PERMS-1:0]   sig_set_reg;

    // item payload
    logic [WORD_W-1:0]      value_reg;
    logic                   first_reg;
    logic                   last_reg;

    // memories
    logic [PROD_W-1:0]      coef_mem [NUM_PERMS];
    logic [WORD_W-1:0]      sig_mem  [NUM_PERMS];
    logic [PROD_W-1:0]      coef_rdata_reg;
    logic [WORD_W-1:0]      sig_rdata_reg;
    logic                   sig_hit_reg;

    // fold pipeline
    logic [AW-1:0]          p1_addr_reg;
    logic [AW-1:0]          p2_addr_reg;
    logic [AW-1:0]          p3_addr_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [WORD_W-1:0]      addend_reg;
    logic [WORD_W-1:0]      old2_reg;
    logic [PROD_W-1:0]      sum_reg;
    logic [WORD_W-1:0]      old3_reg;
    logic [WORD_W-1:0]      hash_word;
    logic [WORD_W-1:0]      sig_min;

    // output side
    logic [AW-1:0]          pend_addr_reg;
    logic [WORD_W-1:0]      out_word_reg;
    logic [AW-1:0]          out_idx_reg;
    logic                   out_final_reg;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   coef_we;
    logic                   emit_issue;
    logic                   pipe_empty;
    logic [WORD_W-1:0]      stored_word;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid_reg && !out_stall;
    assign coef_we    = in_xfer && (func == FUNC_LOAD) && ({1'b0, slot} < PERMS_EXT);
    assign pipe_empty = !p1_vld_reg && !p2_vld_reg && !p3_vld_reg;

    // one read in flight; it always lands in an empty output register
    assign emit_issue = (state_reg == S_EMIT) && !pend_reg && (!out_valid_reg || !out_stall);

    assign stored_word = sig_hit_reg ? sig_rdata_reg : WORD_ONES;

    assign hash_word = mod_m61_low(sum_reg);
    assign sig_min   = (hash_word < old3_reg) ? hash_word : old3_reg;

    assign out_valid      = out_valid_reg;
    assign signature_word = out_word_reg;
    assign slot_index     = SLOT_W'(out_idx_reg);
    assign final_word     = out_final_reg;

    // control state and registered output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            p3_vld_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            sig_set_reg   <= '0;
        end
        else
        begin
            p1_vld_reg <= (state_reg == S_FOLD);
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            pend_reg   <= emit_issue;

            if (p3_vld_reg)
            begin
                sig_set_reg[p3_addr_reg] <= 1'b1;
            end

            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && (func == FUNC_FOLD))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_FOLD;
                    end
                end
                S_FOLD:
                begin
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // wait for the last write-back before reading for output
                    if (pipe_empty)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= last_reg ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (emit_issue)
                    begin
                        cnt_reg <= cnt_reg + AW'(1);
                        if (cnt_reg == LAST_IDX)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // capture the value item
    always_ff @(posedge clk)
    begin
        if (in_xfer && (func == FUNC_FOLD))
        begin
            value_reg <= value;
            first_reg <= first;
            last_reg  <= last;
        end
    end

    // coefficient RAM: {a, b} per slot
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[slot[AW-1:0]] <= {coef_a, coef_b};
        end
        coef_rdata_reg <= coef_mem[cnt_reg];
    end

    // signature RAM: running minimum per slot
    always_ff @(posedge clk)
    begin
        if (p3_vld_reg)
        begin
            sig_mem[p3_addr_reg] <= sig_min;
        end
        sig_rdata_reg <= sig_mem[cnt_reg];
        sig_hit_reg   <= sig_set_reg[cnt_reg];
    end

    // fold pipeline: multiply, add, reduce and take the minimum
    always_ff @(posedge clk)
    begin
        p1_addr_reg <= cnt_reg;

        p2_addr_reg <= p1_addr_reg;
        prod_reg    <= {{(PROD_W-WORD_W){1'b0}}, coef_rdata_reg[PROD_W-1:WORD_W]}
                       * {{(PROD_W-WORD_W){1'b0}}, value_reg};
        addend_reg  <= coef_rdata_reg[WORD_W-1:0];
        old2_reg    <= first_reg ? WORD_ONES : stored_word;

        p3_addr_reg <= p2_addr_reg;
        sum_reg     <= prod_reg + {{(PROD_W-WORD_W){1'b0}}, addend_reg};
        old3_reg    <= old2_reg;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit_issue)
        begin
            pend_addr_reg <= cnt_reg;
        end
        if (pend_reg)
        begin
            out_word_reg  <= stored_word;
            out_idx_reg   <= pend_addr_reg;
            out_final_reg <= (pend_addr_reg == LAST_IDX);
        end
    end

    // read data never lands on a word that still waits for transfer
    a_pend_lands_free: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !out_valid_reg)
        else $error("emit read returned while output register was full");

    // a new item starts only with the fold pipeline empty
    a_accept_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> pipe_empty)
        else $error("input transfer while fold pipeline busy");

    // write-back never overlaps the output sweep
    a_writeback_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
        p3_vld_reg |-> (state_reg == S_FOLD || state_reg == S_DRAIN))
        else $error("signature write-back outside fold");

    // nothing follows the final word of a run
    a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && out_final_reg) |=> !out_valid_reg)
        else $error("result presented right after final word");

endmodule
